// ===== rtl/itl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itl_pkg: shared types and constants
// Holds the controller/datapath command struct, the state enum, status codes and defaults.
// ----------------------------------------------------------------------------
package itl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam logic [10:0] ROWS_RESET = 11'd2;
  localparam logic [30:0] CUTOFF_RESET = 31'd8519680;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_CUTOFF = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CUTOFF = 3'd1;
  localparam logic [2:0] ST_FIRST = 3'd2;
  localparam logic [2:0] ST_NEG = 3'd3;
  localparam logic [2:0] ST_LAST = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PROBE, S_WAIT, S_CMP, S_FIX, S_RD0, S_RD1,
    S_RD2, S_DIV, S_MUL, S_SUM, S_OUT
  } itl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take_item;
    logic check;
    logic probe;
    logic compare;
    logic fix;
    logic rd0;
    logic rd1;
    logic rd2;
    logic div_step;
    logic mul;
    logic sum;
    logic out_load;
  } itl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_load;
    logic early;
    logic found;
    logic search_done;
    logic div_done;
  } itl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/itl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itl_ram: generic single-port ram
// One write and one read of the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
module itl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] addr,
  input  wire  [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/itl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itl_ctrl: query sequencer
// Steps through check, binary search, row reads, division and interpolation.
// ----------------------------------------------------------------------------
module itl_ctrl
  import itl_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        out_full,
  input  itl_sts_t   sts,
  output itl_cmd_t   cmd
);

  itl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, early exits are decided in the cycle after check and after fix
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = sts.is_load ? S_IDLE : S_PROBE;
      S_PROBE: state_nxt = sts.early ? S_OUT : S_WAIT;
      S_WAIT:  state_nxt = S_CMP;
      S_CMP:   state_nxt = (sts.found || sts.search_done) ? S_FIX : S_PROBE;
      S_FIX:   state_nxt = S_RD0;
      S_RD0:   state_nxt = sts.early ? S_OUT : S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_DIV;
      S_DIV:   if (sts.div_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OUT;
      S_OUT:   if (!out_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:  cmd.take_item = in_valid;
      S_CHECK: cmd.check = 1'b1;
      S_PROBE: cmd.probe = 1'b1;
      S_CMP:   cmd.compare = 1'b1;
      S_FIX:   cmd.fix = 1'b1;
      S_RD0:   cmd.rd0 = 1'b1;
      S_RD1:   cmd.rd1 = 1'b1;
      S_RD2:   cmd.rd2 = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_MUL:   cmd.mul = 1'b1;
      S_SUM:   cmd.sum = 1'b1;
      S_OUT:   cmd.out_load = !out_full;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/itl_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itl_dp: lookup datapath
// Table columns, search bounds, serial divider and interpolation arithmetic.
// ----------------------------------------------------------------------------
module itl_dp
  import itl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  itl_cmd_t          cmd,
  output itl_sts_t          sts,
  input  wire               in_action,
  input  wire  [9:0]        in_row_index,
  input  wire signed [31:0] in_row_time,
  input  wire signed [31:0] in_row_position,
  input  wire signed [31:0] in_row_accel,
  input  wire signed [31:0] in_query_time,
  input  wire               cfg_valid,
  input  wire               cfg_index,
  input  wire  [31:0]       cfg_data,
  output logic signed [31:0] res_position,
  output logic signed [31:0] res_accel,
  output logic [2:0]        res_status
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = AW + 2;
  localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);

  logic [10:0] rows_r;
  logic [30:0] cutoff_r;
  logic        act_r;
  logic signed [31:0] qt_r;
  logic signed [IW-1:0] lo_r, hi_r, mid_r, n_r;
  logic [2:0]  st_r;
  logic        early_r, found_r;
  logic [AW-1:0] addr;
  logic        we;
  logic [31:0] tq, pq, aq;
  logic signed [31:0] t0_r, p0_r, a0_r;
  logic signed [32:0] dt_r, span_r, dp_r, da_r;
  // divider
  logic [48:0] dvd_r;
  logic [32:0] dvs_r;
  logic [48:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r, zero_r;
  logic signed [49:0] frac_s;
  logic signed [31:0] frac_c;
  logic signed [65:0] mp_r, ma_r;
  logic signed [IW-1:0] n_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) rows_r <= cfg_data[10:0];
      else cutoff_r <= cfg_data[30:0];
    end
  end

  // saturate row count into the table
  always_comb begin
    if (rows_r < 11'd2) n_sat = IW'(2);
    else if (32'(rows_r) > TABLE_DEPTH) n_sat = DEPTH_I;
    else n_sat = IW'(rows_r);
  end

  // memory address and write enable, loads past the table are dropped
  always_comb begin
    we = cmd.take_item && (in_action == ACT_LOAD) && (32'(in_row_index) < TABLE_DEPTH);
    addr = AW'(mid_r);
    if (we) addr = AW'(in_row_index);
    else if (cmd.rd1) addr = AW'(mid_r + IW'(1));
    else if (cmd.probe || cmd.rd0) addr = AW'(mid_r);
  end

  itl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_time (
    .clk(clk), .we(we), .addr(addr), .wdata(in_row_time), .rdata(tq));
  itl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pos (
    .clk(clk), .we(we), .addr(addr), .wdata(in_row_position), .rdata(pq));
  itl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_acc (
    .clk(clk), .we(we), .addr(addr), .wdata(in_row_accel), .rdata(aq));

  // signed quotient and clamp
  always_comb begin
    frac_s = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
    if (zero_r) frac_c = '0;
    else if (frac_s > 50'sd1073741824) frac_c = 32'sd1073741824;
    else if (frac_s < -50'sd1073741824) frac_c = -32'sd1073741824;
    else frac_c = frac_s[31:0];
  end

  // truncate toward zero by 2^16 then saturate
  function automatic logic signed [31:0] lerp_fin(input logic signed [31:0] a,
                                                   input logic signed [65:0] m);
    logic signed [65:0] q;
    logic signed [66:0] s;
    begin
      q = (m < 0) ? -((-m) >>> 16) : (m >>> 16);
      s = 67'(a) + 67'(q);
      if (s > 67'sd2147483647) lerp_fin = 32'sh7fffffff;
      else if (s < -67'sd2147483648) lerp_fin = 32'sh80000000;
      else lerp_fin = s[31:0];
    end
  endfunction

  // main sequence registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      if (cmd.take_item) begin
        act_r <= in_action;
        qt_r <= in_query_time;
      end
      if (cmd.check) begin
        n_r <= n_sat;
        lo_r <= '0;
        hi_r <= n_sat - IW'(1);
        mid_r <= (n_sat - IW'(1)) >>> 1;
        found_r <= 1'b0;
        if ($signed({qt_r[31], qt_r}) > $signed({2'b0, cutoff_r})) begin
          st_r <= ST_CUTOFF;
          early_r <= 1'b1;
        end else if (qt_r < 0) begin
          st_r <= ST_NEG;
          early_r <= 1'b1;
        end else begin
          st_r <= ST_OK;
          early_r <= 1'b0;
        end
      end
      if (cmd.compare) begin
        if ($signed(tq) < qt_r) begin
          lo_r <= mid_r + IW'(1);
          if (mid_r + IW'(1) <= hi_r) mid_r <= mid_r + IW'(1) + ((hi_r - mid_r - IW'(1)) >>> 1);
          else mid_r <= mid_r + IW'(1);
        end else if ($signed(tq) > qt_r) begin
          hi_r <= mid_r - IW'(1);
          if (lo_r <= mid_r - IW'(1)) mid_r <= lo_r + ((mid_r - IW'(1) - lo_r) >>> 1);
        end else found_r <= 1'b1;
      end
      // step back to the last row below the query, then classify the row
      if (cmd.fix) begin
        if (!found_r && mid_r != 0) begin
          mid_r <= mid_r - IW'(1);
          if (mid_r - IW'(1) == 0) begin
            st_r <= ST_FIRST; early_r <= 1'b1;
          end else if (mid_r - IW'(1) >= n_r - IW'(1)) begin
            st_r <= ST_LAST; early_r <= 1'b1;
          end
        end else if (mid_r == 0) begin
          st_r <= ST_FIRST; early_r <= 1'b1;
        end else if (mid_r >= n_r - IW'(1)) begin
          st_r <= ST_LAST; early_r <= 1'b1;
        end
      end
      // rd0 issues read of row i, rd1 row i+1
      if (cmd.rd1) begin
        t0_r <= tq; p0_r <= pq; a0_r <= aq;
        dt_r <= 33'(qt_r) - 33'($signed(tq));
      end
      if (cmd.rd2) begin
        span_r <= 33'($signed(tq)) - 33'(t0_r);
        dp_r <= 33'($signed(pq)) - 33'(p0_r);
        da_r <= 33'($signed(aq)) - 33'(a0_r);
        zero_r <= (tq == t0_r);
        neg_r <= dt_r[32] ^ ($signed(tq) < t0_r ? 1'b1 : 1'b0) ^ 1'b0;
        dvd_r <= {(dt_r[32] ? -dt_r : dt_r), 16'd0};
        dvs_r <= ($signed(tq) < t0_r) ? (33'(t0_r) - 33'($signed(tq)))
                                      : (33'($signed(tq)) - 33'(t0_r));
        rem_r <= '0;
        cnt_r <= 6'd49;
      end
      // restoring division, one quotient bit a cycle
      if (cmd.div_step && cnt_r != 0) begin
        if ({rem_r, dvd_r[48]} >= {17'd0, dvs_r}) begin
          rem_r <= 49'({rem_r, dvd_r[48]} - {17'd0, dvs_r});
          dvd_r <= {dvd_r[47:0], 1'b1};
        end else begin
          rem_r <= {rem_r[47:0], dvd_r[48]};
          dvd_r <= {dvd_r[47:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      if (cmd.mul) begin
        mp_r <= 66'(frac_c) * 66'(dp_r);
        ma_r <= 66'(frac_c) * 66'(da_r);
      end
      if (cmd.sum) begin
        res_position <= lerp_fin(p0_r, mp_r);
        res_accel <= lerp_fin(a0_r, ma_r);
      end
      if (cmd.check || cmd.fix) begin
        res_position <= '0;
        res_accel <= '0;
      end
    end
  end

  assign res_status = st_r;
  assign sts.is_load = (act_r == ACT_LOAD);
  assign sts.early = early_r;
  assign sts.found = ($signed(tq) == qt_r);
  assign sts.search_done = ($signed(tq) < qt_r) ? (mid_r + IW'(1) > hi_r)
                                                  : (lo_r > mid_r - IW'(1));
  assign sts.div_done = (cnt_r == 6'd0);

endmodule
`default_nettype wire

// ===== rtl/interpolated_table_lookup_top.sv =====
`default_nettype none
// A load is written on accept and returns to idle via check. A query runs check, search
// probes (up to 11 at 1024 rows) of probe, wait and compare on the registered time column
// read, fix, three row reads, a serial divider, multiply, sum and out; cutoff and negative
// queries exit after check, first and last row after fix. One item at a time; after a query,
// the next item is taken the cycle after the result enters the output register. Synchronous
// active-low reset restores rows_in_use 2 and cutoff 130.0 s; table undefined until loaded.
// ----------------------------------------------------------------------------
// interpolated_table_lookup_top: table lookup with linear interpolation
// Controller, datapath and an output register on the result channel.
// ----------------------------------------------------------------------------
module interpolated_table_lookup_top
  import itl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_action,
  input  wire  [9:0]        in_row_index,
  input  wire signed [31:0] in_row_time,
  input  wire signed [31:0] in_row_position,
  input  wire signed [31:0] in_row_accel,
  input  wire signed [31:0] in_query_time,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_accel_out,
  output logic [2:0]        out_status,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_index,
  input  wire  [31:0]       cfg_data
);

  itl_cmd_t cmd;
  itl_sts_t sts;
  logic signed [31:0] res_p, res_a;
  logic [2:0] res_s;
  logic out_valid_r;

  assign cfg_ready = 1'b1;

  itl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_full(out_valid_r && out_stall), .sts(sts), .cmd(cmd));

  itl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_row_index(in_row_index), .in_row_time(in_row_time),
    .in_row_position(in_row_position), .in_row_accel(in_row_accel),
    .in_query_time(in_query_time), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .res_position(res_p), .res_accel(res_a), .res_status(res_s));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
      out_position_out <= res_p;
      out_accel_out <= res_a;
      out_status <= res_s;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
